[hdl/ps2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code decoder package
// Shared constants, result type and the German layout character tables.
// ----------------------------------------------------------------------------
package ps2d_pkg;

	localparam logic [7:0] PFX_E0 = 8'hE0;
	localparam logic [7:0] PFX_E1 = 8'hE1;

	localparam logic [6:0] SC_LSHIFT = 7'd42;
	localparam logic [6:0] SC_RSHIFT = 7'd54;
	localparam logic [6:0] SC_ALT    = 7'd56;
	localparam logic [6:0] SC_CTRL   = 7'd29;
	localparam logic [6:0] SC_CAPS   = 7'd58;
	localparam logic [6:0] SC_SCROLL = 7'd70;
	localparam logic [6:0] SC_NUM    = 7'd69;
	localparam logic [6:0] SC_SLASH  = 7'd53;
	localparam logic [6:0] SC_PAD_LO = 7'd71;
	localparam logic [6:0] SC_PAD_HI = 7'd83;
	localparam logic [6:0] TAB_LEN   = 7'd89;
	localparam logic [6:0] KC_DIV    = 7'd8;

	// Modifier bit positions.
	localparam int M_SHIFT = 0;
	localparam int M_ALTL  = 1;
	localparam int M_ALTR  = 2;
	localparam int M_CTRLL = 3;
	localparam int M_CTRLR = 4;
	localparam int M_CAPS  = 5;
	localparam int M_NUM   = 6;
	localparam int M_SCRL  = 7;

	// One decoded result item.
	typedef struct packed {
		logic [2:0] led_bits;
		logic       led_update;
		logic [7:0] modifier_flags;
		logic [6:0] key_code;
		logic [7:0] ascii_char;
		logic       key_valid;
	} ps2d_res_t;

	function automatic logic [7:0] tab_plain(input logic [6:0] c);
		logic [7:0] r;
		r = 8'd0;
		case (c)
			7'd2: r = "1"; 7'd3: r = "2"; 7'd4: r = "3"; 7'd5: r = "4";
			7'd6: r = "5"; 7'd7: r = "6"; 7'd8: r = "7"; 7'd9: r = "8";
			7'd10: r = "9"; 7'd11: r = "0"; 7'd12: r = 8'd225; 7'd13: r = 8'd39;
			7'd14: r = 8'd8; 7'd16: r = "q"; 7'd17: r = "w"; 7'd18: r = "e";
			7'd19: r = "r"; 7'd20: r = "t"; 7'd21: r = "z"; 7'd22: r = "u";
			7'd23: r = "i"; 7'd24: r = "o"; 7'd25: r = "p"; 7'd26: r = 8'd129;
			7'd27: r = "+"; 7'd28: r = 8'd10; 7'd30: r = "a"; 7'd31: r = "s";
			7'd32: r = "d"; 7'd33: r = "f"; 7'd34: r = "g"; 7'd35: r = "h";
			7'd36: r = "j"; 7'd37: r = "k"; 7'd38: r = "l"; 7'd39: r = 8'd148;
			7'd40: r = 8'd132; 7'd41: r = "^"; 7'd43: r = "#"; 7'd44: r = "y";
			7'd45: r = "x"; 7'd46: r = "c"; 7'd47: r = "v"; 7'd48: r = "b";
			7'd49: r = "n"; 7'd50: r = "m"; 7'd51: r = ","; 7'd52: r = ".";
			7'd53: r = "-"; 7'd55: r = "*"; 7'd57: r = " "; 7'd74: r = "-";
			7'd78: r = "+"; 7'd86: r = "<";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] tab_upper(input logic [6:0] c);
		logic [7:0] r;
		r = 8'd0;
		case (c)
			7'd2: r = "!"; 7'd3: r = 8'd34; 7'd4: r = 8'd21; 7'd5: r = "$";
			7'd6: r = "%"; 7'd7: r = "&"; 7'd8: r = "/"; 7'd9: r = "(";
			7'd10: r = ")"; 7'd11: r = "="; 7'd12: r = "?"; 7'd13: r = 8'd96;
			7'd16: r = "Q"; 7'd17: r = "W"; 7'd18: r = "E"; 7'd19: r = "R";
			7'd20: r = "T"; 7'd21: r = "Z"; 7'd22: r = "U"; 7'd23: r = "I";
			7'd24: r = "O"; 7'd25: r = "P"; 7'd26: r = 8'd154; 7'd27: r = "*";
			7'd30: r = "A"; 7'd31: r = "S"; 7'd32: r = "D"; 7'd33: r = "F";
			7'd34: r = "G"; 7'd35: r = "H"; 7'd36: r = "J"; 7'd37: r = "K";
			7'd38: r = "L"; 7'd39: r = 8'd153; 7'd40: r = 8'd142; 7'd41: r = 8'd248;
			7'd43: r = 8'd39; 7'd44: r = "Y"; 7'd45: r = "X"; 7'd46: r = "C";
			7'd47: r = "V"; 7'd48: r = "B"; 7'd49: r = "N"; 7'd50: r = "M";
			7'd51: r = ";"; 7'd52: r = ":"; 7'd53: r = "_"; 7'd57: r = " ";
			7'd86: r = ">";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] tab_altgr(input logic [6:0] c);
		logic [7:0] r;
		r = 8'd0;
		case (c)
			7'd3: r = 8'd253; 7'd8: r = "{"; 7'd9: r = "["; 7'd10: r = "]";
			7'd11: r = "}"; 7'd12: r = 8'd92; 7'd16: r = "@"; 7'd27: r = "~";
			7'd50: r = 8'd230; 7'd86: r = "|";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// Keypad character and remapped key code, indexed by code minus 71.
	function automatic logic [14:0] tab_pad(input logic [3:0] i);
		logic [14:0] r;
		r = 15'd0;
		case (i)
			4'd0: r = {7'd8, 8'("7")};   4'd1: r = {7'd9, 8'("8")};
			4'd2: r = {7'd10, 8'("9")};  4'd3: r = {7'd53, 8'("-")};
			4'd4: r = {7'd5, 8'("4")};   4'd5: r = {7'd6, 8'("5")};
			4'd6: r = {7'd7, 8'("6")};   4'd7: r = {7'd27, 8'("+")};
			4'd8: r = {7'd2, 8'("1")};   4'd9: r = {7'd3, 8'("2")};
			4'd10: r = {7'd4, 8'("3")};  4'd11: r = {7'd11, 8'("0")};
			4'd12: r = {7'd51, 8'(",")};
			default: r = 15'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/ps2d_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 decoder core
// Holds prefix and modifier state and decodes one registered byte per cycle while step is set.
// ----------------------------------------------------------------------------
module ps2d_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          code,
	output ps2d_pkg::ps2d_res_t res
);
	import ps2d_pkg::*;

	logic [7:0] prefix_q;
	logic [7:0] mod_q;
	logic [7:0] mod_d;
	logic [7:0] prefix_d;
	logic [6:0] c;
	logic       e0;
	logic       done;
	logic       led;
	logic [7:0] ch;
	logic [6:0] kc;
	logic       letter;
	logic [3:0] pidx;
	logic [14:0] pad;

	assign c      = code[6:0];
	assign e0     = (prefix_q == PFX_E0);
	assign letter = (c >= 7'd16 && c <= 7'd26) || (c >= 7'd30 && c <= 7'd40) ||
	                (c >= 7'd44 && c <= 7'd50);
	assign pidx   = 4'(c - SC_PAD_LO);
	assign pad    = tab_pad(pidx);

	// Character lookup under the layout priority.
	always_comb begin
		kc = c;
		if (c == SC_SLASH && e0) begin
			ch = "/";
			kc = KC_DIV;
		end else if (mod_q[M_NUM] && prefix_q == 8'd0 && c >= SC_PAD_LO &&
		             c <= SC_PAD_HI) begin
			ch = pad[7:0];
			kc = pad[14:8];
		end else if (c >= TAB_LEN) begin
			ch = 8'd0;
		end else if (mod_q[M_ALTR]) begin
			ch = tab_altgr(c);
		end else if (mod_q[M_SHIFT] || (mod_q[M_CAPS] && letter)) begin
			ch = tab_upper(c);
		end else begin
			ch = tab_plain(c);
		end
	end

	// Modifier, lock and prefix update.
	always_comb begin
		mod_d    = mod_q;
		prefix_d = 8'd0;
		done     = 1'b0;
		led      = 1'b0;
		if (code == PFX_E0 || code == PFX_E1) begin
			prefix_d = code;
		end else if (code[7]) begin
			if (c == SC_LSHIFT || c == SC_RSHIFT) mod_d[M_SHIFT] = 1'b0;
			else if (c == SC_ALT) begin
				if (e0) mod_d[M_ALTR] = 1'b0;
				else mod_d[M_ALTL] = 1'b0;
			end else if (c == SC_CTRL) begin
				if (e0) mod_d[M_CTRLR] = 1'b0;
				else mod_d[M_CTRLL] = 1'b0;
			end
		end else if (c == SC_LSHIFT || c == SC_RSHIFT) begin
			mod_d[M_SHIFT] = 1'b1;
		end else if (c == SC_ALT) begin
			if (e0) mod_d[M_ALTR] = 1'b1;
			else mod_d[M_ALTL] = 1'b1;
		end else if (c == SC_CTRL) begin
			if (e0) mod_d[M_CTRLR] = 1'b1;
			else mod_d[M_CTRLL] = 1'b1;
		end else if (c == SC_CAPS) begin
			mod_d[M_CAPS] = ~mod_q[M_CAPS];
			led = 1'b1;
		end else if (c == SC_SCROLL) begin
			mod_d[M_SCRL] = ~mod_q[M_SCRL];
			led = 1'b1;
		end else if (c == SC_NUM && !mod_q[M_CTRLL]) begin
			mod_d[M_NUM] = ~mod_q[M_NUM];
			led = 1'b1;
		end else begin
			done = 1'b1;
		end
	end

	// Result assembly.
	always_comb begin
		res = '0;
		if (done) begin
			res.key_valid      = 1'b1;
			res.ascii_char     = ch;
			res.key_code       = kc;
			res.modifier_flags = mod_d;
		end
		if (led) begin
			res.led_update = 1'b1;
			res.led_bits   = {mod_d[M_CAPS], mod_d[M_NUM], mod_d[M_SCRL]};
		end
	end

	// State registers advance once per decoded byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 8'd0;
			mod_q    <= 8'd0;
		end else if (step) begin
			prefix_q <= prefix_d;
			mod_q    <= mod_d;
		end
	end

endmodule

[hdl/ps2_scancode_to_ascii_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code set 1 decoder
// Turns keyboard bytes into German layout characters and modifier flags.
// ----------------------------------------------------------------------------
// One result is produced for every accepted byte, registered in the output
// register after the byte has passed the input register; bytes may be sent in
// every cycle. The rate is set by the combinational decode between the input
// and output registers, and backpressure from the output stalls the input
// register only when both hold an item.
module ps2_scancode_to_ascii_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] scan_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] key_valid, [8:1] ascii_char, [15:9] key_code, [23:16] modifier_flags,
	// [24] led_update, [27:25] led_bits, [31:28] zero
	output logic [31:0] m_axis_tdata
);
	import ps2d_pkg::*;

	logic       in_vld_s1;
	logic [7:0] in_data_s1;
	logic       out_vld_s2;
	ps2d_res_t  res_s2;
	ps2d_res_t  res;
	logic       adv;

	// Stage 1 moves on when stage 2 is empty or drains.
	assign adv           = !out_vld_s2 || m_axis_tready;
	assign s_axis_tready = !in_vld_s1 || adv;

	ps2d_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (in_vld_s1 && adv),
		.code  (in_data_s1),
		.res   (res)
	);

	// Input and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1  <= 1'b0;
			out_vld_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) in_vld_s1 <= s_axis_tvalid;
			if (adv) out_vld_s2 <= in_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) in_data_s1 <= s_axis_tdata;
		if (adv && in_vld_s1) res_s2 <= res;
	end

	assign m_axis_tvalid = out_vld_s2;
	assign m_axis_tdata  = {4'd0, res_s2};

	// A stalled result must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// A decoded key never comes with a lock update.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[24]))
		else $error("key and LED update together");

	// Without a lock update the LED bits read zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[24] |-> m_axis_tdata[27:25] == 3'd0)
		else $error("LED bits without update");

endmodule

[verif/ps2_scancode_to_ascii_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 scan code decoder testbench
// Sends scan code bytes over the input stream with random gaps, predicts
// every decoded result and compares it field by field with the output
// stream, which stalls at random. A directed table comes first, then random
// key sequences with prefixes, modifiers, locks and noise.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_decoder_tb;
	import ps2d_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	// Predictor state.
	logic [7:0] pfx_q;
	logic [7:0] mods_q;

	ps2d_res_t  pending_results[$];
	int         mismatch_cnt;
	int         result_cnt;
	int         sent_cnt;
	int         key_cnt;
	int         led_cnt;
	int         gap_max;

	// Directed table: byte, and an expected word that is used when fixed is set.
	typedef struct {
		logic [7:0] code;
		bit         fixed;
		logic [31:0] want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	ps2_scancode_to_ascii_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Letter keys honor caps lock.
	function automatic bit letter_key(input logic [6:0] c);
		return (c >= 16 && c <= 26) || (c >= 30 && c <= 40) || (c >= 44 && c <= 50);
	endfunction

	function automatic logic [7:0] plain_char(input logic [6:0] c);
		case (c)
			2: return "1"; 3: return "2"; 4: return "3"; 5: return "4";
			6: return "5"; 7: return "6"; 8: return "7"; 9: return "8";
			10: return "9"; 11: return "0"; 12: return 8'd225; 13: return 8'd39;
			14: return 8'd8; 16: return "q"; 17: return "w"; 18: return "e";
			19: return "r"; 20: return "t"; 21: return "z"; 22: return "u";
			23: return "i"; 24: return "o"; 25: return "p"; 26: return 8'd129;
			27: return "+"; 28: return 8'd10; 30: return "a"; 31: return "s";
			32: return "d"; 33: return "f"; 34: return "g"; 35: return "h";
			36: return "j"; 37: return "k"; 38: return "l"; 39: return 8'd148;
			40: return 8'd132; 41: return "^"; 43: return "#"; 44: return "y";
			45: return "x"; 46: return "c"; 47: return "v"; 48: return "b";
			49: return "n"; 50: return "m"; 51: return ","; 52: return ".";
			53: return "-"; 55: return "*"; 57: return " "; 74: return "-";
			78: return "+"; 86: return "<";
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] shift_char(input logic [6:0] c);
		case (c)
			2: return "!"; 3: return 8'd34; 4: return 8'd21; 5: return "$";
			6: return "%"; 7: return "&"; 8: return "/"; 9: return "(";
			10: return ")"; 11: return "="; 12: return "?"; 13: return 8'd96;
			16: return "Q"; 17: return "W"; 18: return "E"; 19: return "R";
			20: return "T"; 21: return "Z"; 22: return "U"; 23: return "I";
			24: return "O"; 25: return "P"; 26: return 8'd154; 27: return "*";
			30: return "A"; 31: return "S"; 32: return "D"; 33: return "F";
			34: return "G"; 35: return "H"; 36: return "J"; 37: return "K";
			38: return "L"; 39: return 8'd153; 40: return 8'd142; 41: return 8'd248;
			43: return 8'd39; 44: return "Y"; 45: return "X"; 46: return "C";
			47: return "V"; 48: return "B"; 49: return "N"; 50: return "M";
			51: return ";"; 52: return ":"; 53: return "_"; 57: return " ";
			86: return ">";
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] altgr_char(input logic [6:0] c);
		case (c)
			3: return 8'd253; 8: return "{"; 9: return "["; 10: return "]";
			11: return "}"; 12: return 8'd92; 16: return "@"; 27: return "~";
			50: return 8'd230; 86: return "|";
			default: return 8'd0;
		endcase
	endfunction

	// Predicts the result of one byte and advances the predictor state.
	function automatic ps2d_res_t decode_byte(input logic [7:0] b);
		ps2d_res_t r;
		logic [6:0] c;
		bit e0, key, led;
		string pc;
		logic [6:0] pk[0:12];
		r = '0;
		c = b[6:0];
		e0 = (pfx_q == PFX_E0);
		key = 0;
		led = 0;
		pc = "789-456+1230,";
		pk = '{7'd8, 7'd9, 7'd10, 7'd53, 7'd5, 7'd6, 7'd7, 7'd27, 7'd2, 7'd3, 7'd4,
			7'd11, 7'd51};
		if (b == PFX_E0 || b == PFX_E1) begin
			pfx_q = b;
			return r;
		end
		if (b[7]) begin
			if (c == SC_LSHIFT || c == SC_RSHIFT) mods_q[M_SHIFT] = 1'b0;
			else if (c == SC_ALT) mods_q[e0 ? M_ALTR : M_ALTL] = 1'b0;
			else if (c == SC_CTRL) mods_q[e0 ? M_CTRLR : M_CTRLL] = 1'b0;
			pfx_q = 8'd0;
			return r;
		end
		if (c == SC_LSHIFT || c == SC_RSHIFT) mods_q[M_SHIFT] = 1'b1;
		else if (c == SC_ALT) mods_q[e0 ? M_ALTR : M_ALTL] = 1'b1;
		else if (c == SC_CTRL) mods_q[e0 ? M_CTRLR : M_CTRLL] = 1'b1;
		else if (c == SC_CAPS) begin
			mods_q[M_CAPS] = ~mods_q[M_CAPS]; led = 1;
		end else if (c == SC_SCROLL) begin
			mods_q[M_SCRL] = ~mods_q[M_SCRL]; led = 1;
		end else if (c == SC_NUM && !mods_q[M_CTRLL]) begin
			mods_q[M_NUM] = ~mods_q[M_NUM]; led = 1;
		end else begin
			key = 1;
			r.key_code = c;
			if (c == SC_SLASH && e0) begin
				r.ascii_char = "/";
				r.key_code = KC_DIV;
			end else if (mods_q[M_NUM] && pfx_q == 8'd0 && c >= SC_PAD_LO && c <= SC_PAD_HI) begin
				r.ascii_char = pc[c - 71];
				r.key_code = pk[c - 71];
			end else if (mods_q[M_ALTR]) r.ascii_char = altgr_char(c);
			else if (mods_q[M_SHIFT]) r.ascii_char = shift_char(c);
			else if (mods_q[M_CAPS] && letter_key(c)) r.ascii_char = shift_char(c);
			else r.ascii_char = plain_char(c);
		end
		pfx_q = 8'd0;
		if (key) begin
			r.key_valid = 1'b1;
			r.modifier_flags = mods_q;
		end
		if (led) begin
			r.led_update = 1'b1;
			r.led_bits = {mods_q[M_CAPS], mods_q[M_NUM], mods_q[M_SCRL]};
		end
		return r;
	endfunction

	// Sends one byte with a random gap ahead of it and queues its prediction.
	task automatic send_code(input logic [7:0] b, input bit fixed, input logic [31:0] want);
		ps2d_res_t p;
		int gap;
		gap = $urandom_range(0, gap_max);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		p = decode_byte(b);
		if (fixed && p != ps2d_res_t'(want[27:0])) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("table row for %h: predictor %h, table %h", b, p, want[27:0]);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		pending_results.push_back(p);
		sent_cnt++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Random byte from a well-formed key stream, with a share of noise.
	function automatic logic [7:0] pick_code();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) return 8'($urandom_range(0, 255));
		if (sel < 20) return {1'($urandom_range(0, 1)), SC_LSHIFT};
		if (sel < 25) return {1'($urandom_range(0, 1)), SC_ALT};
		if (sel < 30) return {1'($urandom_range(0, 1)), SC_CTRL};
		if (sel < 35) return ($urandom_range(0, 1) ? PFX_E0 : PFX_E1);
		if (sel < 40) return {1'b0, ($urandom_range(0, 2) == 0 ? SC_CAPS :
			($urandom_range(0, 1) ? SC_NUM : SC_SCROLL))};
		if (sel < 55) return 8'($urandom_range(71, 83));
		if (sel < 60) return {1'b0, SC_SLASH};
		if (sel < 65) return 8'($urandom_range(89, 127));
		return 8'($urandom_range(0, 88));
	endfunction

	// Output checker and random backpressure.
	always @(posedge clk) begin
		ps2d_res_t got;
		ps2d_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ps2d_res_t'(m_axis_tdata[27:0]);
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_r = pending_results.pop_front();
				result_cnt++;
				if (got.key_valid) key_cnt++;
				if (got.led_update) led_cnt++;
				if (got !== exp_r || m_axis_tdata[31:28] !== 4'd0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: exp valid=%b ch=%h kc=%0d mod=%h led=%b bits=%b",
							exp_r.key_valid, exp_r.ascii_char, exp_r.key_code,
							exp_r.modifier_flags, exp_r.led_update, exp_r.led_bits,
							" got valid=%b ch=%h kc=%0d mod=%h led=%b bits=%b",
							got.key_valid, got.ascii_char, got.key_code,
							got.modifier_flags, got.led_update, got.led_bits);
				end
			end
		end
		if (arst_n) m_axis_tready <= ($urandom_range(0, 9) < (($urandom_range(0, 3) == 0) ? 10 : 6));
	end

	// Stimulus.
	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		pfx_q = 8'd0;
		mods_q = 8'd0;
		mismatch_cnt = 0;
		result_cnt = 0;
		sent_cnt = 0;
		key_cnt = 0;
		led_cnt = 0;
		gap_max = 9;
		// Fixed rows: word layout {led_bits, led_update, mods, key_code, char, valid}.
		dir_rows = '{
			'{8'd0,   1, {4'd0, 3'd0, 1'b0, 8'h00, 7'd0, 8'd0, 1'b1}},
			'{8'd30,  1, {4'd0, 3'd0, 1'b0, 8'h00, 7'd30, 8'h61, 1'b1}},
			'{8'd127, 1, {4'd0, 3'd0, 1'b0, 8'h00, 7'd127, 8'd0, 1'b1}},
			'{8'd255, 1, 32'd0},
			'{8'd58,  1, {4'd0, 3'd4, 1'b1, 8'h00, 7'd0, 8'd0, 1'b0}},
			'{8'd30,  0, 32'd0},
			'{8'd58,  1, {4'd0, 3'd0, 1'b1, 8'h00, 7'd0, 8'd0, 1'b0}},
			'{8'd70,  1, {4'd0, 3'd1, 1'b1, 8'h00, 7'd0, 8'd0, 1'b0}},
			'{8'd42,  1, 32'd0},
			'{8'd2,   0, 32'd0},
			'{8'd170, 1, 32'd0},
			'{8'd224, 1, 32'd0},
			'{8'd56,  0, 32'd0},
			'{8'd16,  0, 32'd0},
			'{8'd224, 0, 32'd0},
			'{8'd184, 0, 32'd0},
			'{8'd224, 0, 32'd0},
			'{8'd53,  0, 32'd0},
			'{8'd29,  0, 32'd0},
			'{8'd69,  0, 32'd0},
			'{8'd157, 0, 32'd0},
			'{8'd69,  0, 32'd0},
			'{8'd71,  0, 32'd0},
			'{8'd225, 0, 32'd0},
			'{8'd83,  0, 32'd0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send_code(dir_rows[i].code, dir_rows[i].fixed, dir_rows[i].want);
		for (i = 0; i < 600; i++) begin
			// One long hold-off until every result has drained.
			if (i == 300) begin
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			// Stretches with no input gaps.
			gap_max = (i >= 400 && i < 450) ? 0 : 9;
			send_code(pick_code(), 0, 32'd0);
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d scan codes, got %0d results: %0d keys, %0d lock changes.",
			sent_cnt, result_cnt, key_cnt, led_cnt);
		if (mismatch_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
